// ===== hw/rtl/box_downsample_rgba_macros.svh =====
// ---------------------------------------------------------------------------
// box_downsample_rgba_macros
// assertion shorthands shared by the downsampler rtl, clocked on clk with rst
// ---------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_RGBA_MACROS_SVH
`define BOX_DOWNSAMPLE_RGBA_MACROS_SVH

// same-cycle implication
`define BDSR_CHECK(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define BDSR_CHECK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/bdsr_pkg.sv =====
// ---------------------------------------------------------------------------
// bdsr_pkg
// shared constants, types and the block-area reciprocal table
// ---------------------------------------------------------------------------
package bdsr_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int MAX_SHRINK  = 16;
  localparam int SHRINK_W    = 5;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int BLK_W       = 4;
  localparam int MAX_DIM     = 4096;
  localparam int PIX_W       = 8;
  localparam int SUM_W       = 16;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;
  localparam int IDX_W       = 2;

  localparam logic [IDX_W-1:0] REG_SHRINK = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              emit;
    logic              eor;
    logic              eof;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  alpha;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] alpha;
  } sums_t;

  // ceil(2^24 / (s*s)), exact floor division for sums below 2^16
  function automatic logic [RECIP_W-1:0] recip(input logic [SHRINK_W-1:0] s);
    logic [RECIP_W-1:0] m;
    unique case (s)
      5'd2:    m = 25'd4194304;
      5'd3:    m = 25'd1864136;
      5'd4:    m = 25'd1048576;
      5'd5:    m = 25'd671089;
      5'd6:    m = 25'd466034;
      5'd7:    m = 25'd342393;
      5'd8:    m = 25'd262144;
      5'd9:    m = 25'd207127;
      5'd10:   m = 25'd167773;
      5'd11:   m = 25'd138655;
      5'd12:   m = 25'd116509;
      5'd13:   m = 25'd99274;
      5'd14:   m = 25'd85599;
      5'd15:   m = 25'd74566;
      5'd16:   m = 25'd65536;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/bdsr_ram.sv =====
// ---------------------------------------------------------------------------
// bdsr_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bdsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bdsr_queue.sv =====
// ---------------------------------------------------------------------------
// bdsr_queue
// short fifo of classified pixel operations between front and back
// ---------------------------------------------------------------------------
`include "box_downsample_rgba_macros.svh"

module bdsr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bdsr_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bdsr_pkg::entry_t  head
);

  bdsr_pkg::entry_t                    slots [bdsr_pkg::Q_DEPTH];
  logic [bdsr_pkg::Q_PTR_W-1:0]        wr_ptr;
  logic [bdsr_pkg::Q_PTR_W-1:0]        rd_ptr;
  logic [bdsr_pkg::Q_CNT_W-1:0]        count;

  assign full       = (count == bdsr_pkg::Q_CNT_W'(bdsr_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BDSR_CHECK(a_count_bound, 1'b1, count <= bdsr_pkg::Q_CNT_W'(bdsr_pkg::Q_DEPTH), "queue count over depth")
  `BDSR_CHECK_NEXT(a_push_lands, push && !pop, count != '0, "pushed entry missing")

endmodule

// ===== hw/rtl/bdsr_front.sv =====
// ---------------------------------------------------------------------------
// bdsr_front
// config registers, raster position tracking and pixel classification
// ---------------------------------------------------------------------------
`include "box_downsample_rgba_macros.svh"

module bdsr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdsr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bdsr_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bdsr_pkg::PIX_W-1:0]      in_red,
  input  logic [bdsr_pkg::PIX_W-1:0]      in_green,
  input  logic [bdsr_pkg::PIX_W-1:0]      in_blue,
  input  logic [bdsr_pkg::PIX_W-1:0]      in_alpha,
  input  logic                            q_full,
  output logic                            push,
  output bdsr_pkg::entry_t                push_entry,
  output logic [bdsr_pkg::SHRINK_W-1:0]   shrink
);

  logic [bdsr_pkg::DIM_W-1:0]  width;
  logic [bdsr_pkg::DIM_W-1:0]  height;
  logic [bdsr_pkg::POS_W-1:0]  src_col;
  logic [bdsr_pkg::POS_W-1:0]  src_row;
  logic [bdsr_pkg::BLK_W-1:0]  col_in_blk;
  logic [bdsr_pkg::BLK_W-1:0]  row_in_blk;
  logic [bdsr_pkg::POS_W-1:0]  blk_col;
  logic [bdsr_pkg::POS_W-1:0]  blk_row;
  logic [bdsr_pkg::ADDR_W-1:0] out_col;

  logic                        accept;
  logic                        cfg_hit;
  logic [bdsr_pkg::DIM_W:0]    col_end;
  logic [bdsr_pkg::DIM_W:0]    col_end2;
  logic [bdsr_pkg::DIM_W:0]    row_end;
  logic [bdsr_pkg::DIM_W:0]    row_end2;
  logic                        col_ok;
  logic                        row_ok;
  logic                        cib_wrap;
  logic                        rib_wrap;
  logic                        col_wrap;
  logic                        row_wrap;
  logic [bdsr_pkg::SHRINK_W-1:0] shrink_in;
  logic [bdsr_pkg::DIM_W-1:0]  dim_in;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_index == bdsr_pkg::REG_SHRINK ||
                               cfg_index == bdsr_pkg::REG_WIDTH  ||
                               cfg_index == bdsr_pkg::REG_HEIGHT);

  // clamp incoming register values
  always_comb begin
    priority if (cfg_data[bdsr_pkg::SHRINK_W-1:0] == '0) begin
      shrink_in = bdsr_pkg::SHRINK_W'(1);
    end else if (cfg_data[bdsr_pkg::SHRINK_W-1:0] >
                 bdsr_pkg::SHRINK_W'(bdsr_pkg::MAX_SHRINK)) begin
      shrink_in = bdsr_pkg::SHRINK_W'(bdsr_pkg::MAX_SHRINK);
    end else begin
      shrink_in = cfg_data[bdsr_pkg::SHRINK_W-1:0];
    end
    priority if (cfg_data == '0) begin
      dim_in = bdsr_pkg::DIM_W'(1);
    end else if (cfg_data > bdsr_pkg::DIM_W'(bdsr_pkg::MAX_DIM)) begin
      dim_in = bdsr_pkg::DIM_W'(bdsr_pkg::MAX_DIM);
    end else begin
      dim_in = cfg_data;
    end
  end

  // block fits inside the frame, and whether it is the last one across or down
  assign col_end  = (bdsr_pkg::DIM_W+1)'(blk_col) + (bdsr_pkg::DIM_W+1)'(shrink);
  assign col_end2 = col_end + (bdsr_pkg::DIM_W+1)'(shrink);
  assign row_end  = (bdsr_pkg::DIM_W+1)'(blk_row) + (bdsr_pkg::DIM_W+1)'(shrink);
  assign row_end2 = row_end + (bdsr_pkg::DIM_W+1)'(shrink);
  assign col_ok   = col_end <= {1'b0, width};
  assign row_ok   = row_end <= {1'b0, height};

  assign cib_wrap = (bdsr_pkg::SHRINK_W'(col_in_blk) + 1'b1) >= shrink;
  assign rib_wrap = (bdsr_pkg::SHRINK_W'(row_in_blk) + 1'b1) >= shrink;
  assign col_wrap = (bdsr_pkg::DIM_W'(src_col) + 1'b1) >= width;
  assign row_wrap = (bdsr_pkg::DIM_W'(src_row) + 1'b1) >= height;

  assign push = accept && col_ok && row_ok;

  always_comb begin
    push_entry.addr  = out_col;
    push_entry.first = (col_in_blk == '0) && (row_in_blk == '0);
    push_entry.emit  = cib_wrap && rib_wrap;
    push_entry.eor   = col_end2 > {1'b0, width};
    push_entry.eof   = (col_end2 > {1'b0, width}) && (row_end2 > {1'b0, height});
    push_entry.red   = in_red;
    push_entry.green = in_green;
    push_entry.blue  = in_blue;
    push_entry.alpha = in_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shrink     <= bdsr_pkg::SHRINK_W'(1);
      width      <= bdsr_pkg::DIM_W'(640);
      height     <= bdsr_pkg::DIM_W'(480);
      src_col    <= '0;
      src_row    <= '0;
      col_in_blk <= '0;
      row_in_blk <= '0;
      blk_col    <= '0;
      blk_row    <= '0;
      out_col    <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        bdsr_pkg::REG_SHRINK: shrink <= shrink_in;
        bdsr_pkg::REG_WIDTH:  width  <= dim_in;
        default:              height <= dim_in;
      endcase
      src_col    <= '0;
      src_row    <= '0;
      col_in_blk <= '0;
      row_in_blk <= '0;
      blk_col    <= '0;
      blk_row    <= '0;
      out_col    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        src_col    <= '0;
        col_in_blk <= '0;
        blk_col    <= '0;
        out_col    <= '0;
        if (row_wrap) begin
          src_row    <= '0;
          row_in_blk <= '0;
          blk_row    <= '0;
        end else begin
          src_row <= src_row + 1'b1;
          if (rib_wrap) begin
            row_in_blk <= '0;
            blk_row    <= blk_row + bdsr_pkg::POS_W'(shrink);
          end else begin
            row_in_blk <= row_in_blk + 1'b1;
          end
        end
      end else begin
        src_col <= src_col + 1'b1;
        if (cib_wrap) begin
          col_in_blk <= '0;
          blk_col    <= blk_col + bdsr_pkg::POS_W'(shrink);
          out_col    <= out_col + 1'b1;
        end else begin
          col_in_blk <= col_in_blk + 1'b1;
        end
      end
    end
  end

  `BDSR_CHECK(a_cib_in_block, 1'b1, bdsr_pkg::SHRINK_W'(col_in_blk) < shrink, "column offset past block")
  `BDSR_CHECK_NEXT(a_frame_wrap, accept && col_wrap && row_wrap, src_col == '0 && src_row == '0 && row_in_blk == '0, "frame did not restart")

endmodule

// ===== hw/rtl/bdsr_back.sv =====
// ---------------------------------------------------------------------------
// bdsr_back
// column sum read-modify-write, area scaling and output register
// ---------------------------------------------------------------------------
`include "box_downsample_rgba_macros.svh"

module bdsr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  bdsr_pkg::entry_t              q_head,
  output logic                          q_pop,
  input  logic [bdsr_pkg::SHRINK_W-1:0] shrink,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdsr_pkg::PIX_W-1:0]    out_red,
  output logic [bdsr_pkg::PIX_W-1:0]    out_green,
  output logic [bdsr_pkg::PIX_W-1:0]    out_blue,
  output logic [bdsr_pkg::PIX_W-1:0]    out_alpha,
  output logic                          end_of_row,
  output logic                          end_of_frame
);

  function automatic logic [bdsr_pkg::PIX_W-1:0] scale(
    input logic [bdsr_pkg::SUM_W-1:0]   sum,
    input logic [bdsr_pkg::RECIP_W-1:0] m
  );
    logic [bdsr_pkg::PROD_W-1:0] p;
    p = bdsr_pkg::PROD_W'(sum) * bdsr_pkg::PROD_W'(m);
    return p[bdsr_pkg::RECIP_SHIFT +: bdsr_pkg::PIX_W];
  endfunction

  bdsr_pkg::entry_t              s2_op;
  logic                          s2_valid;
  logic                          s2_hit;
  bdsr_pkg::sums_t               s2_hit_data;
  bdsr_pkg::sums_t               rdata;
  bdsr_pkg::sums_t               base;
  bdsr_pkg::sums_t               sum;
  logic                          s2_done;
  logic                          s2_can;

  bdsr_pkg::sums_t               s3_sums;
  logic                          s3_valid;
  logic                          s3_eor;
  logic                          s3_eof;
  logic                          s3_can;
  logic                          out_can;
  logic [bdsr_pkg::RECIP_W-1:0]  m;

  assign out_can = !out_valid || out_ready;
  assign s3_can  = !s3_valid || out_can;
  assign s2_done = s2_valid && (!s2_op.emit || s3_can);
  assign s2_can  = !s2_valid || s2_done;
  assign q_pop   = q_valid && s2_can;

  bdsr_ram #(
    .WIDTH ($bits(bdsr_pkg::sums_t)),
    .DEPTH (bdsr_pkg::MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (s2_done),
    .waddr (s2_op.addr),
    .wdata (sum),
    .re    (q_pop),
    .raddr (q_head.addr),
    .rdata (rdata)
  );

  always_comb begin
    priority if (s2_op.first) begin
      base = '0;
    end else if (s2_hit) begin
      base = s2_hit_data;
    end else begin
      base = rdata;
    end
    sum.red   = base.red   + bdsr_pkg::SUM_W'(s2_op.red);
    sum.green = base.green + bdsr_pkg::SUM_W'(s2_op.green);
    sum.blue  = base.blue  + bdsr_pkg::SUM_W'(s2_op.blue);
    sum.alpha = base.alpha + bdsr_pkg::SUM_W'(s2_op.alpha);
  end

  // same column written on the edge of the read: take the new sum directly
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_op       <= q_head;
      s2_hit      <= s2_done && (s2_op.addr == q_head.addr);
      s2_hit_data <= sum;
    end
    if (s2_done && s2_op.emit) begin
      s3_sums <= sum;
      s3_eor  <= s2_op.eor;
      s3_eof  <= s2_op.eof;
    end
  end

  assign m = bdsr_pkg::recip(shrink);

  always_ff @(posedge clk) begin
    if (s3_valid && out_can) begin
      out_red      <= scale(s3_sums.red,   m);
      out_green    <= scale(s3_sums.green, m);
      out_blue     <= scale(s3_sums.blue,  m);
      out_alpha    <= scale(s3_sums.alpha, m);
      end_of_row   <= s3_eor;
      end_of_frame <= s3_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_can) begin
        s2_valid <= q_pop;
      end
      if (s3_can) begin
        s3_valid <= s2_done && s2_op.emit;
      end
      if (out_can) begin
        out_valid <= s3_valid;
      end
    end
  end

  `BDSR_CHECK_NEXT(a_emit_lands, s2_done && s2_op.emit, s3_valid, "block result lost before scaling")
  `BDSR_CHECK(a_hit_same_col, s2_valid && s2_hit, !s2_op.first || s2_hit, "forwarded sum on fresh block")

endmodule

// ===== hw/rtl/box_downsample_rgba.sv =====
// ---------------------------------------------------------------------------
// box_downsample_rgba
// integer-factor box-filter downsampler for raster rgba pixels
// ---------------------------------------------------------------------------
//  channel   handshake                  payload
//  cfg       cfg_we                     cfg_index, cfg_data
//  in        in_valid / in_ready        in_red, in_green, in_blue, in_alpha
//  out       out_valid / out_ready      out_red .. out_alpha, end_of_row, end_of_frame
//
//  one pixel per cycle sustained while out_ready stays high; a block result leaves
//  after its last pixel transfer through the queue, the sum ram's registered read and the scaling stage
//  a 4-entry queue separates position tracking from the sum ram pipeline
//  out_ready low fills the pipeline and queue, then drops in_ready
//  reset restores register defaults and restarts the frame; sums need no clearing
// ---------------------------------------------------------------------------
module box_downsample_rgba (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bdsr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bdsr_pkg::DIM_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdsr_pkg::PIX_W-1:0]    in_red,
  input  logic [bdsr_pkg::PIX_W-1:0]    in_green,
  input  logic [bdsr_pkg::PIX_W-1:0]    in_blue,
  input  logic [bdsr_pkg::PIX_W-1:0]    in_alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdsr_pkg::PIX_W-1:0]    out_red,
  output logic [bdsr_pkg::PIX_W-1:0]    out_green,
  output logic [bdsr_pkg::PIX_W-1:0]    out_blue,
  output logic [bdsr_pkg::PIX_W-1:0]    out_alpha,
  output logic                          end_of_row,
  output logic                          end_of_frame
);

  logic                          push;
  bdsr_pkg::entry_t              push_entry;
  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;
  bdsr_pkg::entry_t              q_head;
  logic [bdsr_pkg::SHRINK_W-1:0] shrink;

  bdsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_alpha   (in_alpha),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry),
    .shrink     (shrink)
  );

  bdsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bdsr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .shrink       (shrink),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

endmodule

// ===== dv/box_downsample_rgba_checker.sv =====
// ---------------------------------------------------------------------------
// box_downsample_rgba_checker
// watches the config port and both pixel channels, predicts each block
// average from the accepted source pixels and compares it with the output
// ---------------------------------------------------------------------------
module box_downsample_rgba_checker
  import bdsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [PIX_W-1:0]   in_red,
  input  logic [PIX_W-1:0]   in_green,
  input  logic [PIX_W-1:0]   in_blue,
  input  logic [PIX_W-1:0]   in_alpha,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PIX_W-1:0]   out_red,
  input  logic [PIX_W-1:0]   out_green,
  input  logic [PIX_W-1:0]   out_blue,
  input  logic [PIX_W-1:0]   out_alpha,
  input  logic               end_of_row,
  input  logic               end_of_frame,
  output int                 mismatch_count,
  output int                 results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             eor;
    logic             eof;
  } block_avg_t;

  logic [SHRINK_W-1:0] shrink_reg;
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  int unsigned         src_col;
  int unsigned         src_row;
  int unsigned         col_in_blk;
  int unsigned         row_in_blk;
  int unsigned         blk_col;
  int unsigned         blk_row;
  int unsigned         block_sum [MAX_WIDTH][4];
  block_avg_t          expected_avgs [$];
  block_avg_t          head;

  task automatic restart_frame();
    src_col = 0;
    src_row = 0;
    col_in_blk = 0;
    row_in_blk = 0;
    blk_col = 0;
    blk_row = 0;
  endtask

  task automatic accumulate_pixel(input logic [4*PIX_W-1:0] pix);
    int unsigned s;
    int unsigned w;
    int unsigned h;
    int unsigned ow;
    int unsigned oh;
    int unsigned area;
    int          ch;
    bit          opens_blk;
    logic [PIX_W-1:0] avg [4];
    block_avg_t  result;
    s = (shrink_reg == 0) ? 1 : ((shrink_reg > MAX_SHRINK) ? MAX_SHRINK : shrink_reg);
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
    ow = w / s;
    oh = h / s;
    if (blk_col < ow && blk_row < oh) begin
      opens_blk = (col_in_blk == 0) && (row_in_blk == 0);
      for (ch = 0; ch < 4; ch++) begin
        block_sum[blk_col][ch] = (opens_blk ? 0 : block_sum[blk_col][ch])
                               + pix[(3-ch)*PIX_W +: PIX_W];
      end
      if (col_in_blk == s - 1 && row_in_blk == s - 1) begin
        area = s * s;
        for (ch = 0; ch < 4; ch++) begin
          avg[ch] = PIX_W'(block_sum[blk_col][ch] / area);
        end
        result.red   = avg[0];
        result.green = avg[1];
        result.blue  = avg[2];
        result.alpha = avg[3];
        result.eor   = (blk_col == ow - 1);
        result.eof   = (blk_col == ow - 1) && (blk_row == oh - 1);
        expected_avgs.push_back(result);
      end
    end
    src_col++;
    col_in_blk++;
    if (col_in_blk >= s) begin
      col_in_blk = 0;
      blk_col++;
    end
    if (src_col >= w) begin
      src_col = 0;
      col_in_blk = 0;
      blk_col = 0;
      src_row++;
      row_in_blk++;
      if (row_in_blk >= s) begin
        row_in_blk = 0;
        blk_row++;
      end
      if (src_row >= h) begin
        restart_frame();
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [PIX_W-1:0] want_val,
                               input logic [PIX_W-1:0] got_val);
    if (got_val !== want_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      // register defaults
      shrink_reg = 1;
      width_reg = 640;
      height_reg = 480;
      restart_frame();
      expected_avgs.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHRINK: begin
            shrink_reg = cfg_data[SHRINK_W-1:0];
            restart_frame();
          end
          REG_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          REG_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_avgs.size() == 0) begin
          $error("output transfer with no block average pending: %0d %0d %0d %0d",
                 out_red, out_green, out_blue, out_alpha);
          mismatch_count++;
        end else begin
          head = expected_avgs.pop_front();
          compare_field("out_red", head.red, out_red);
          compare_field("out_green", head.green, out_green);
          compare_field("out_blue", head.blue, out_blue);
          compare_field("out_alpha", head.alpha, out_alpha);
          compare_field("end_of_row", PIX_W'(head.eor), PIX_W'(end_of_row));
          compare_field("end_of_frame", PIX_W'(head.eof), PIX_W'(end_of_frame));
        end
      end
      if (in_valid && in_ready) begin
        accumulate_pixel({in_red, in_green, in_blue, in_alpha});
      end
    end
    results_due = expected_avgs.size();
  end

endmodule

// ===== dv/box_downsample_rgba_tb.sv =====
// ---------------------------------------------------------------------------
// box_downsample_rgba_tb
// drives raster rgba frames of many sizes and shrink factors through the
// downsampler under varying source gaps and sink stalls; the checker beside
// the block predicts every block average and reports mismatches
// ---------------------------------------------------------------------------
module box_downsample_rgba_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdsr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 340;
  localparam int WIDE_ITEMS   = 64;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DIM_W-1:0] data;
  } reg_write_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;
  logic [PIX_W-1:0] in_alpha = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_alpha;
  logic             end_of_row;
  logic             end_of_frame;
  int               mismatch_count;
  int               results_due;

  int               send_gap_pct = 0;
  int               stall_pct = 0;
  int               cycle_count = 0;
  int               random_sent = 0;
  reg_write_t       reg_writes [$];

  box_downsample_rgba DUT (.*);

  box_downsample_rgba_checker avg_check (.*);

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(input idling_t mode);
    unique case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 83;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct = 83;
      end
      default: begin
        send_gap_pct = 21;
        stall_pct = 21;
      end
    endcase
  endtask

  function automatic rgba_t random_pixel();
    logic [4*PIX_W-1:0] bits;
    int                 ch;
    bits = $urandom;
    for (ch = 0; ch < 4; ch++) begin
      if ($urandom_range(7) == 0) begin
        bits[ch*PIX_W +: PIX_W] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      end
    end
    return rgba_t'(bits);
  endfunction

  // enters and leaves on a falling edge
  task automatic send_pixel(input rgba_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= px.red;
    in_green <= px.green;
    in_blue <= px.blue;
    in_alpha <= px.alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) begin
      send_pixel(random_pixel());
      random_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic commit_writes();
    wait_idle();
    foreach (reg_writes[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_writes[i].idx;
      cfg_data <= reg_writes[i].data;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    reg_writes.delete();
  endtask

  task automatic configure(input logic [DIM_W-1:0] shrink_val, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    reg_writes.push_back('{REG_SHRINK, shrink_val});
    reg_writes.push_back('{REG_WIDTH, w});
    reg_writes.push_back('{REG_HEIGHT, h});
    commit_writes();
  endtask

  initial begin
    logic [DIM_W-1:0] shrink_val;
    int unsigned      s;
    int unsigned      w;
    int unsigned      h;
    int unsigned      total;
    int unsigned      cut;
    int unsigned      pick;

    set_idling(IDLE_NONE);
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // register defaults pass pixels through
    send_pixel(rgba_t'(32'h00000000));
    send_pixel(rgba_t'(32'hFFFFFFFF));
    send_pixel(rgba_t'(32'hA55A3CC3));
    // zero registers read as one: every pixel ends a frame
    configure(13'd0, 13'd0, 13'd0);
    send_pixel(rgba_t'(32'hFF00FF00));
    send_pixel(rgba_t'(32'h00FF00FF));
    configure(13'd3, 13'd3, 13'd3);
    send_random(9);
    // image smaller than one block
    configure(13'd4, 13'd2, 13'd3);
    send_random(6);
    configure(13'd2, 13'd2, 13'd2);
    repeat (4) send_pixel('1);

    set_idling(idling_t'($urandom_range(3)));
    configure(13'd16, 13'd16, 13'd16);
    repeat (256) send_pixel('1);
    set_idling(idling_t'($urandom_range(3)));
    configure(13'd1, 13'h1FFF, 13'd1);
    send_random(WIDE_ITEMS);
    set_idling(idling_t'($urandom_range(3)));
    configure(13'd1, 13'd1, 13'h1FFF);
    send_random(WIDE_ITEMS);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_idling(idling_t'($urandom_range(3)));
      pick = $urandom_range(31);
      if (pick == 24 || pick == 25) shrink_val = DIM_W'($urandom_range(5, 8));
      else if (pick == 26) shrink_val = DIM_W'($urandom_range(9, 16));
      else if (pick == 27) shrink_val = '0;
      else if (pick == 28) shrink_val = DIM_W'($urandom_range(17, 31));
      else if (pick == 29) shrink_val = DIM_W'($urandom_range(8191));
      else shrink_val = DIM_W'($urandom_range(1, 4));
      s = 32'(shrink_val[SHRINK_W-1:0]);
      if (s == 0) s = 1;
      if (s > MAX_SHRINK) s = MAX_SHRINK;
      if ($urandom_range(5) == 0) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end else if (s > 4) begin
        w = s * $urandom_range(1, 2) + $urandom_range(0, 2);
        h = s;
      end else begin
        w = s * $urandom_range(1, 6) + $urandom_range(0, s - 1);
        h = s * $urandom_range(1, 3) + $urandom_range(0, s - 1);
      end
      configure(shrink_val, DIM_W'(w), DIM_W'(h));
      total = $urandom_range(1, 2) * w * h;
      if (total > RANDOM_ITEMS - random_sent) total = RANDOM_ITEMS - random_sent;
      if ($urandom_range(4) == 0 && total > 1) begin
        // abandoned frame, or one interrupted by a write to no register
        cut = $urandom_range(1, total - 1);
        send_random(cut);
        if ($urandom_range(1) != 0) begin
          reg_writes.push_back('{REG_UNUSED, DIM_W'($urandom)});
          commit_writes();
          send_random(total - cut);
        end
      end else begin
        send_random(total);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== box_downsample_rgba.f =====
+incdir+hw/rtl
hw/rtl/bdsr_pkg.sv
hw/rtl/bdsr_ram.sv
hw/rtl/bdsr_queue.sv
hw/rtl/bdsr_front.sv
hw/rtl/bdsr_back.sv
hw/rtl/box_downsample_rgba.sv
dv/box_downsample_rgba_checker.sv
dv/box_downsample_rgba_tb.sv
